@@ hw/rtl/isc_pkg.sv @@
`default_nettype none
package isc_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int COORD_WIDTH   = 32;
  localparam int ORIG_W        = 5;
  localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERLAP  = 2'd1;
  localparam logic [1:0] ST_GAP      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] left;
    logic signed [COORD_WIDTH-1:0] right;
    logic [ORIG_W-1:0]             origin;
  } cell_item_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic occupied;
    logic prev_occupied;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/interval_sort_contiguity_check_top.sv @@
// Interval sort with contiguity check.
// Input channel (in_valid/in_ready): one interval per item, left_end and
// right_end as signed Q16.16, last_item marks the final interval of a run.
// While loading, one item is taken every cycle; the first MAX_INTERVALS items
// go into a chain of MAX_INTERVALS cells, stable by left_end, as they arrive.
// After the final item the chain rotates once through all MAX_INTERVALS
// cells, comparing rank k's right end with rank k+1's left end at the head.
// Then either one status item (overlap, gap or too many intervals,
// original_index 0) or item_count index items follow on the output channel
// (out_valid/out_ready), one per cycle while not stalled.
// An overflowed run skips the rotation and goes straight to its status
// item. A stalled receiver holds the output register and, while emitting,
// the chain; no input is taken from the final item of a run until the last
// result is registered.
// Synchronous reset empties the chain and clears the overflow flag; cell
// contents are not cleared.
`default_nettype none
module interval_sort_contiguity_check_top import isc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] left_end,
  input  logic signed [COORD_WIDTH-1:0] right_end,
  input  logic                          last_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ORIG_W-1:0]             original_index,
  output logic [1:0]                    status,
  output logic                          last_result
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_CHECK = 4'b0010,
    S_EMIT  = 4'b0100,
    S_ERROR = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              overflow_seen, overflow_seen_next;
  logic [IDX_W-1:0]  step, step_next;
  logic [1:0]        chk_status, chk_status_next;

  cell_item_t               items [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] gts;
  logic [MAX_INTERVALS-1:0] occ;
  cell_item_t               new_item;

  logic accept, has_room, slot_free, do_insert, do_shift, emit_last, load_out;
  logic [CNT_W-1:0] step_plus;

  assign in_ready  = (state == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign has_room  = (count < CNT_W'(MAX_INTERVALS));
  assign do_insert = accept && has_room;
  assign slot_free = !out_valid || out_ready;
  assign step_plus = CNT_W'(step) + CNT_W'(1);
  assign emit_last = (step_plus == count);
  assign load_out  = slot_free && ((state == S_EMIT) || (state == S_ERROR));
  assign do_shift  = (state == S_CHECK) || ((state == S_EMIT) && slot_free);

  assign new_item.left   = left_end;
  assign new_item.right  = right_end;
  assign new_item.origin = ORIG_W'(count);

  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      occ[i] = (CNT_W'(i) < count);
    end
  end

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.insert        = do_insert;
    assign ctl.shift         = do_shift;
    assign ctl.occupied      = occ[i];
    assign ctl.prev_occupied = (i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1];
    isc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_item  (new_item),
      .prev_item (items[(i == 0) ? 0 : i-1]),
      .next_item (items[(i + 1) % MAX_INTERVALS]),
      .prev_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i-1]),
      .item      (items[i]),
      .gt        (gts[i])
    );
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    overflow_seen_next = overflow_seen;
    step_next          = step;
    chk_status_next    = chk_status;
    case (state)
      S_LOAD: begin
        if (accept) begin
          if (has_room) begin
            count_next = count + CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          if (last_item) begin
            step_next       = '0;
            chk_status_next = ST_OK;
            if (overflow_seen || !has_room) begin
              chk_status_next = ST_OVERFLOW;
              state_next      = S_ERROR;
            end else begin
              state_next = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        if ((step_plus < count) && (chk_status == ST_OK)) begin
          if (items[1 % MAX_INTERVALS].left < items[0].right) begin
            chk_status_next = ST_OVERLAP;
          end else if (items[1 % MAX_INTERVALS].left > items[0].right) begin
            chk_status_next = ST_GAP;
          end
        end
        step_next = step + IDX_W'(1);
        if (step == IDX_W'(MAX_INTERVALS - 1)) begin
          step_next  = '0;
          state_next = (chk_status_next == ST_OK) ? S_EMIT : S_ERROR;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          step_next = step + IDX_W'(1);
          if (emit_last) begin
            count_next         = '0;
            overflow_seen_next = 1'b0;
            state_next         = S_LOAD;
          end
        end
      end
      S_ERROR: begin
        if (slot_free) begin
          count_next         = '0;
          overflow_seen_next = 1'b0;
          state_next         = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      step          <= '0;
      chk_status    <= ST_OK;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_seen <= overflow_seen_next;
      step          <= step_next;
      chk_status    <= chk_status_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_EMIT) begin
        original_index <= items[0].origin;
        status         <= ST_OK;
        last_result    <= emit_last;
      end else begin
        original_index <= '0;
        status         <= chk_status;
        last_result    <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_INTERVALS))
    else $error("item count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) && (step != IDX_W'(MAX_INTERVALS - 1))
      |=> (state == S_CHECK) && (step == $past(step) + IDX_W'(1)))
    else $error("check rotation did not advance");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last_result && (original_index == '0))
    else $error("status item not final or carries an index");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && slot_free && emit_last |=> (count == '0) && !overflow_seen)
    else $error("run state not cleared after final result");

endmodule
`default_nettype wire

@@ hw/rtl/isc_cell.sv @@
`default_nettype none
module isc_cell import isc_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  cell_item_t new_item,
  input  cell_item_t prev_item,
  input  cell_item_t next_item,
  input  logic       prev_gt,
  output cell_item_t item,
  output logic       gt
);

  assign gt = ctl.occupied && (item.left > new_item.left);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      item <= next_item;
    end else if (ctl.insert) begin
      if (prev_gt) begin
        item <= prev_item;
      end else if (gt || (!ctl.occupied && ctl.prev_occupied)) begin
        item <= new_item;
      end
    end
  end

endmodule
`default_nettype wire
